// ===== src/mcbd_pkg.sv =====
// mcbd_pkg: shared types, constants and channel arithmetic for the mip chain generator.
// Used by every module under src; depends on nothing.
package mcbd_pkg;

	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;
	localparam int DEF_MAX_LEVELS = 12;

	localparam int CFG_DATA_W  = 12;
	localparam int CFG_INDEX_W = 2;
	localparam int LEVEL_W     = 4;
	localparam int COORD_W     = 11;
	localparam int CHAN_W      = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_COUNT  = 2'd2;

	// {alpha, blue, green, red}, red in the low byte
	typedef logic [4*CHAN_W-1:0] pixel_t;
	// four 9-bit horizontal pair sums, same channel order
	typedef logic [4*(CHAN_W+1)-1:0] pairs_t;

	typedef enum logic {
		ST_IDLE,
		ST_COMBINE
	} eng_state_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		pixel_t             pix;
		logic               last;
	} result_t;

	function automatic pairs_t pair_sums(input pixel_t a, input pixel_t b);
		pairs_t r;
		r = '0;
		for (int c = 0; c < 4; c++) begin
			r[(CHAN_W+1)*c +: (CHAN_W+1)] = {1'b0, a[CHAN_W*c +: CHAN_W]}
				+ {1'b0, b[CHAN_W*c +: CHAN_W]};
		end
		return r;
	endfunction

	function automatic pixel_t block_average(input pairs_t upper, input pairs_t lower);
		pixel_t             r;
		logic [CHAN_W+1:0]  s;
		r = '0;
		for (int c = 0; c < 4; c++) begin
			s = {1'b0, upper[(CHAN_W+1)*c +: (CHAN_W+1)]}
				+ {1'b0, lower[(CHAN_W+1)*c +: (CHAN_W+1)]};
			r[CHAN_W*c +: CHAN_W] = s[CHAN_W+1:2];
		end
		return r;
	endfunction

endpackage

// ===== src/mcbd_line_store.sv =====
// mcbd_line_store: pair-sum line memory, one write and one read port, registered read data.
// Holds the even-row pair sums of every level; entry layout from mcbd_pkg::pairs_t.
module mcbd_line_store #(
	parameter int DEPTH  = mcbd_pkg::DEF_MAX_WIDTH,
	parameter int ADDR_W = $clog2(mcbd_pkg::DEF_MAX_WIDTH)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  mcbd_pkg::pairs_t    wr_data,
	input  logic                re,
	input  logic [ADDR_W-1:0]   rd_addr,
	output mcbd_pkg::pairs_t    rd_data
);

	mcbd_pkg::pairs_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/mcbd_out_fifo.sv =====
// mcbd_out_fifo: two-entry result queue between the step engine and the result channel.
// Uses mcbd_pkg::result_t.
module mcbd_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mcbd_pkg::result_t   push_data,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output mcbd_pkg::result_t   out_data
);

	mcbd_pkg::result_t slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              pop;

	assign room      = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = slot_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== src/mip_chain_box_downsample.sv =====
// mip_chain_box_downsample: streaming 2x2 box-filter mip chain generator, raster RGBA8 in.
// Path: input register, step engine, result queue; each higher level passes the step engine once more.
// The single step unit makes one line-store access per level; it takes no new input until the
// higher-level results of the last one are done, and it stalls while the result queue is full.
// Reset: arst_n clears counters, config (to 1), input register and result queue; the line
// store and the per-level left pixels are not cleared and are always written before use.
module mip_chain_box_downsample #(
	parameter int MAX_WIDTH  = mcbd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mcbd_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_LEVELS = mcbd_pkg::DEF_MAX_LEVELS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [mcbd_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [mcbd_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  pix_valid,
	output logic                                  pix_ready,
	input  logic [mcbd_pkg::CHAN_W-1:0]           red_in,
	input  logic [mcbd_pkg::CHAN_W-1:0]           green_in,
	input  logic [mcbd_pkg::CHAN_W-1:0]           blue_in,
	input  logic [mcbd_pkg::CHAN_W-1:0]           alpha_in,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output logic [mcbd_pkg::LEVEL_W-1:0]          mip_level,
	output logic [mcbd_pkg::COORD_W-1:0]          col,
	output logic [mcbd_pkg::COORD_W-1:0]          row,
	output logic [mcbd_pkg::CHAN_W-1:0]           red_out,
	output logic [mcbd_pkg::CHAN_W-1:0]           green_out,
	output logic [mcbd_pkg::CHAN_W-1:0]           blue_out,
	output logic [mcbd_pkg::CHAN_W-1:0]           alpha_out,
	output logic                                  last
);

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int YW  = $clog2(MAX_HEIGHT);
	localparam int WW  = XW + 1;
	localparam int HW  = YW + 1;
	localparam int LD  = MAX_LEVELS - 1;
	localparam int LIW = (LD > 1) ? $clog2(LD) : 1;
	localparam int LW  = mcbd_pkg::LEVEL_W;

	// configuration, held saturated
	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [LW-1:0] lc_q;
	logic [WW-1:0] w_wr;
	logic [HW-1:0] h_wr;
	logic [LW-1:0] lc_wr;
	logic          cfg_hit;

	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;

	// input register
	logic             in_full_q;
	mcbd_pkg::pixel_t in_pix_q;
	logic             pix_xfer;

	// step engine
	mcbd_pkg::eng_state_t state_q, state_d;
	logic [LW-1:0]        s_q;
	logic [XW-1:0]        x_q;
	logic [YW-1:0]        y_q;
	mcbd_pkg::pairs_t     pairs_q;
	mcbd_pkg::pixel_t     left_q [LD];

	logic             room;
	logic             take;
	logic             step_fire;
	logic [LW-1:0]    st_s;
	logic [XW-1:0]    st_x;
	logic [YW-1:0]    st_y;
	mcbd_pkg::pixel_t st_pix;
	mcbd_pkg::pixel_t left_rd;
	mcbd_pkg::pairs_t pairs;
	logic [WW-1:0]    idx_full;
	logic             idx_ok;
	logic             active;
	logic             cont;
	logic             left_we;
	logic             mem_we;
	logic             mem_re;
	mcbd_pkg::pairs_t mem_rd;

	mcbd_pkg::result_t push_data;
	mcbd_pkg::result_t out_data;

	// ---------------- configuration ----------------
	always_comb begin
		w_wr = (cfg_data == '0) ? WW'(1)
			: (32'(cfg_data) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_data);
		h_wr = (cfg_data == '0) ? HW'(1)
			: (32'(cfg_data) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
		lc_wr = (cfg_data[LW-1:0] == '0) ? LW'(1)
			: (cfg_data[LW-1:0] > LW'(MAX_LEVELS)) ? LW'(MAX_LEVELS) : cfg_data[LW-1:0];
	end

	always_comb begin
		unique case (cfg_index)
			mcbd_pkg::REG_IMAGE_WIDTH,
			mcbd_pkg::REG_IMAGE_HEIGHT,
			mcbd_pkg::REG_LEVEL_COUNT: cfg_hit = cfg_we;
			default:                   cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q  <= WW'(1);
			h_q  <= HW'(1);
			lc_q <= LW'(1);
		end else if (cfg_we) begin
			if (cfg_index == mcbd_pkg::REG_IMAGE_WIDTH) begin
				w_q <= w_wr;
			end
			if (cfg_index == mcbd_pkg::REG_IMAGE_HEIGHT) begin
				h_q <= h_wr;
			end
			if (cfg_index == mcbd_pkg::REG_LEVEL_COUNT) begin
				lc_q <= lc_wr;
			end
		end
	end

	// raster counters, advanced when an item enters the engine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if ((WW'(col_q) + WW'(1)) >= w_q) begin
				col_q <= '0;
				if ((HW'(row_q) + HW'(1)) >= h_q) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + YW'(1);
				end
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	// ---------------- input register ----------------
	assign pix_ready = !in_full_q || take;
	assign pix_xfer  = pix_valid && pix_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_full_q <= 1'b0;
		end else if (pix_xfer) begin
			in_full_q <= 1'b1;
		end else if (take) begin
			in_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_xfer) begin
			in_pix_q <= {alpha_in, blue_in, green_in, red_in};
		end
	end

	// ---------------- step engine ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mcbd_pkg::ST_IDLE: begin
				if (take && cont) begin
					state_d = mcbd_pkg::ST_COMBINE;
				end
			end
			mcbd_pkg::ST_COMBINE: begin
				if (room && !cont) begin
					state_d = mcbd_pkg::ST_IDLE;
				end
			end
			default: state_d = mcbd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		take      = (state_q == mcbd_pkg::ST_IDLE) && in_full_q && room;
		step_fire = take || ((state_q == mcbd_pkg::ST_COMBINE) && room);
		if (state_q == mcbd_pkg::ST_COMBINE) begin
			st_s   = s_q;
			st_x   = x_q;
			st_y   = y_q;
			st_pix = mcbd_pkg::block_average(mem_rd, pairs_q);
		end else begin
			st_s   = '0;
			st_x   = col_q;
			st_y   = row_q;
			st_pix = in_pix_q;
		end
		left_rd  = left_q[st_s[LIW-1:0]];
		pairs    = mcbd_pkg::pair_sums(left_rd, st_pix);
		idx_full = WW'(MAX_WIDTH) - (WW'(MAX_WIDTH) >> st_s) + WW'(st_x >> 1);
		idx_ok   = idx_full < WW'(MAX_WIDTH);
		active   = ((5'(st_s) + 5'd1) < 5'(lc_q));
		cont     = active && st_x[0] && idx_ok && st_y[0];
		left_we  = step_fire && active && !st_x[0];
		mem_we   = step_fire && active && st_x[0] && idx_ok && !st_y[0];
		mem_re   = step_fire && cont;

		push_data.level = st_s;
		push_data.col   = mcbd_pkg::COORD_W'(st_x);
		push_data.row   = mcbd_pkg::COORD_W'(st_y);
		push_data.pix   = st_pix;
		push_data.last  = !cont;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcbd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			s_q     <= st_s + LW'(1);
			x_q     <= st_x >> 1;
			y_q     <= st_y >> 1;
			pairs_q <= pairs;
		end
		if (left_we) begin
			left_q[st_s[LIW-1:0]] <= st_pix;
		end
	end

	mcbd_line_store #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (XW)
	) u_line_store (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (idx_full[XW-1:0]),
		.wr_data (pairs),
		.re      (mem_re),
		.rd_addr (idx_full[XW-1:0]),
		.rd_data (mem_rd)
	);

	mcbd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step_fire),
		.push_data (push_data),
		.room      (room),
		.out_valid (res_valid),
		.out_ready (res_ready),
		.out_data  (out_data)
	);

	assign mip_level = out_data.level;
	assign col       = out_data.col;
	assign row       = out_data.row;
	assign red_out   = out_data.pix[7:0];
	assign green_out = out_data.pix[15:8];
	assign blue_out  = out_data.pix[23:16];
	assign alpha_out = out_data.pix[31:24];
	assign last      = out_data.last;

endmodule

// ===== src/mcbd_checker.sv =====
// mcbd_port_checks: port-level checks on the mip chain generator, bound to its top level.
// Depends on mcbd_pkg and mip_chain_box_downsample.
module mcbd_port_checks (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  pix_valid,
	input logic                                  pix_ready,
	input logic [mcbd_pkg::CHAN_W-1:0]           red_in,
	input logic                                  res_valid,
	input logic                                  res_ready,
	input logic [mcbd_pkg::LEVEL_W-1:0]          mip_level,
	input logic [mcbd_pkg::COORD_W-1:0]          col,
	input logic [mcbd_pkg::COORD_W-1:0]          row,
	input logic [mcbd_pkg::CHAN_W-1:0]           red_out,
	input logic                                  last
);

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(mip_level) && $stable(col)
			&& $stable(row) && $stable(red_out) && $stable(last))
		else $error("result changed while stalled");

	// stalled input holds
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(red_in))
		else $error("input changed while stalled");

	// a cascade never leaves a gap once its first result is taken
	a_cascade: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !last |=> res_valid)
		else $error("next result of a cascade missing");

	// nothing to show and room to take in the cycle after reset
	a_reset: assert property (@(posedge clk)
		$past(!arst_n) && arst_n |-> !res_valid && pix_ready)
		else $error("bad state after reset");

endmodule

bind mip_chain_box_downsample mcbd_port_checks u_port_checks (.*);

// ===== tb/sv/mcbd_checker.sv =====
// mcbd_checker: watches the pixel, result and register ports of the mip chain generator,
// predicts every result from its own counters, line store and left pixels, and counts mismatches.
// Depends on mcbd_pkg for widths, register indexes and the pixel and result layouts.
module mcbd_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mcbd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mcbd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             pix_valid,
	input  logic                             pix_ready,
	input  logic [mcbd_pkg::CHAN_W-1:0]      red_in,
	input  logic [mcbd_pkg::CHAN_W-1:0]      green_in,
	input  logic [mcbd_pkg::CHAN_W-1:0]      blue_in,
	input  logic [mcbd_pkg::CHAN_W-1:0]      alpha_in,
	input  logic                             res_valid,
	input  logic                             res_ready,
	input  logic [mcbd_pkg::LEVEL_W-1:0]     mip_level,
	input  logic [mcbd_pkg::COORD_W-1:0]     col,
	input  logic [mcbd_pkg::COORD_W-1:0]     row,
	input  logic [mcbd_pkg::CHAN_W-1:0]      red_out,
	input  logic [mcbd_pkg::CHAN_W-1:0]      green_out,
	input  logic [mcbd_pkg::CHAN_W-1:0]      blue_out,
	input  logic [mcbd_pkg::CHAN_W-1:0]      alpha_out,
	input  logic                             last,
	output int                               pending,
	output int                               fails
);
	timeunit 1ns;
	timeprecision 1ps;
	import mcbd_pkg::*;

	localparam int LINE_DEPTH = DEF_MAX_WIDTH;
	localparam int SUM_W      = CHAN_W + 1;
	localparam int MAX_SHOWN  = 10;

	logic [CFG_DATA_W-1:0] width_reg;
	logic [CFG_DATA_W-1:0] height_reg;
	logic [LEVEL_W-1:0]    levels_reg;
	int                    x_pos;
	int                    y_pos;
	pairs_t                line_sums [LINE_DEPTH];
	pixel_t                left_px [DEF_MAX_LEVELS-1];
	result_t               due_q [$];
	result_t               want;

	function automatic int clamp_dim(input int v, input int ceiling);
		return (v == 0) ? 1 : ((v > ceiling) ? ceiling : v);
	endfunction

	task automatic predict_pixel(input pixel_t px);
		int      w, h, lc, x, y, lvl, slot, acc, c;
		bit      climbing;
		pixel_t  cur, prev;
		pairs_t  hsum, upper;
		result_t r;
		w  = clamp_dim(width_reg, DEF_MAX_WIDTH);
		h  = clamp_dim(height_reg, DEF_MAX_HEIGHT);
		lc = clamp_dim(levels_reg, DEF_MAX_LEVELS);
		if (x_pos >= w) x_pos = 0;
		if (y_pos >= h) y_pos = 0;
		cur = px;
		x = x_pos;
		y = y_pos;
		lvl = 0;
		r.level = '0;
		r.col = COORD_W'(x);
		r.row = COORD_W'(y);
		r.pix = cur;
		r.last = 1'b0;
		climbing = 1'b1;
		while (climbing && lvl + 1 < lc && lvl < DEF_MAX_LEVELS - 1) begin
			slot = LINE_DEPTH - (LINE_DEPTH >> lvl) + (x >> 1);
			if ((x & 1) == 0) begin
				left_px[lvl] = cur;
				climbing = 1'b0;
			end else begin
				prev = left_px[lvl];
				for (c = 0; c < 4; c++)
					hsum[SUM_W*c +: SUM_W] = SUM_W'(int'(prev[CHAN_W*c +: CHAN_W])
						+ int'(cur[CHAN_W*c +: CHAN_W]));
				if (slot >= LINE_DEPTH) begin
					climbing = 1'b0;
				end else if ((y & 1) == 0) begin
					line_sums[slot] = hsum;
					climbing = 1'b0;
				end else begin
					upper = line_sums[slot];
					for (c = 0; c < 4; c++) begin
						acc = int'(upper[SUM_W*c +: SUM_W]) + int'(hsum[SUM_W*c +: SUM_W]);
						cur[CHAN_W*c +: CHAN_W] = CHAN_W'(acc >> 2);
					end
					lvl++;
					x = x >> 1;
					y = y >> 1;
					due_q = {due_q, r};
					r.level = LEVEL_W'(lvl);
					r.col = COORD_W'(x);
					r.row = COORD_W'(y);
					r.pix = cur;
				end
			end
		end
		r.last = 1'b1;
		due_q = {due_q, r};
		x_pos++;
		if (x_pos >= w) begin
			x_pos = 0;
			y_pos++;
			if (y_pos >= h) y_pos = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = 1;
			height_reg = 1;
			levels_reg = 1;
			x_pos = 0;
			y_pos = 0;
			due_q.delete();
			pending <= 0;
			fails <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: begin
						width_reg = cfg_data;
						x_pos = 0;
						y_pos = 0;
					end
					REG_IMAGE_HEIGHT: begin
						height_reg = cfg_data;
						x_pos = 0;
						y_pos = 0;
					end
					REG_LEVEL_COUNT: begin
						levels_reg = cfg_data[LEVEL_W-1:0];
						x_pos = 0;
						y_pos = 0;
					end
					default: ;
				endcase
			end
			if (pix_valid && pix_ready)
				predict_pixel({alpha_in, blue_in, green_in, red_in});
			if (res_valid && res_ready) begin
				if (due_q.size() == 0) begin
					if (fails < MAX_SHOWN)
						$display("unexpected result transfer: level %0d col %0d row %0d",
							mip_level, col, row);
					fails <= fails + 1;
				end else begin
					want = due_q.pop_front();
					if (mip_level !== want.level || col !== want.col || row !== want.row
						|| red_out !== want.pix[CHAN_W*0 +: CHAN_W]
						|| green_out !== want.pix[CHAN_W*1 +: CHAN_W]
						|| blue_out !== want.pix[CHAN_W*2 +: CHAN_W]
						|| alpha_out !== want.pix[CHAN_W*3 +: CHAN_W]
						|| last !== want.last) begin
						if (fails < MAX_SHOWN)
							$display({"result mismatch: got L%0d (%0d,%0d) abgr %h last %b, ",
								"exp L%0d (%0d,%0d) abgr %h last %b"},
								mip_level, col, row, {alpha_out, blue_out, green_out, red_out},
								last, want.level, want.col, want.row, want.pix, want.last);
						fails <= fails + 1;
					end
				end
			end
			pending <= due_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_mip_chain_box_downsample.sv =====
// tb_mip_chain_box_downsample: drives raster RGBA8 images under several geometries and level
// counts into the mip chain generator, with random stalls on both sides; gives the verdict.
// Depends on mcbd_pkg, mip_chain_box_downsample and mcbd_checker.
module tb_mip_chain_box_downsample;
	timeunit 1ns;
	timeprecision 1ps;
	import mcbd_pkg::*;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 4;
	localparam int SETTLE_CYCLES = 20;
	localparam int STALL_LIMIT   = 4000;
	localparam int LONG_HOLD     = 400;
	localparam int RANDOM_ITEMS  = 120;
	localparam int MAX_BURST     = 40;
	localparam int BACKUP_ITEMS  = 40;
	localparam int BACKUP_HOLD   = 4;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   pix_valid;
	logic                   pix_ready;
	logic [CHAN_W-1:0]      red_in;
	logic [CHAN_W-1:0]      green_in;
	logic [CHAN_W-1:0]      blue_in;
	logic [CHAN_W-1:0]      alpha_in;
	logic                   res_valid;
	logic                   res_ready;
	logic [LEVEL_W-1:0]     mip_level;
	logic [COORD_W-1:0]     col;
	logic [COORD_W-1:0]     row;
	logic [CHAN_W-1:0]      red_out;
	logic [CHAN_W-1:0]      green_out;
	logic [CHAN_W-1:0]      blue_out;
	logic [CHAN_W-1:0]      alpha_out;
	logic                   last;
	int                     pending;
	int                     fails;
	bit                     calm = 1'b0;
	int                     hold_asks = 0;

	mip_chain_box_downsample uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.alpha_in  (alpha_in),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.mip_level (mip_level),
		.col       (col),
		.row       (row),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.alpha_out (alpha_out),
		.last      (last)
	);

	mcbd_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.alpha_in  (alpha_in),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.mip_level (mip_level),
		.col       (col),
		.row       (row),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.alpha_out (alpha_out),
		.last      (last),
		.pending   (pending),
		.fails     (fails)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	task automatic set_geometry(input int w, input int h, input int lc);
		cfg_we <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= CFG_DATA_W'(w);
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data <= CFG_DATA_W'(h);
		@(posedge clk);
		cfg_index <= REG_LEVEL_COUNT;
		cfg_data <= CFG_DATA_W'(lc);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_pixel(input pixel_t px);
		if (!calm && $urandom_range(0, 5) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		pix_valid <= 1'b1;
		{alpha_in, blue_in, green_in, red_in} <= px;
		do @(posedge clk); while (pix_ready !== 1'b1);
	endtask

	task automatic drain_results();
		pix_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic pixel_t random_pixel();
		pixel_t px;
		int     c;
		px = $urandom();
		if ($urandom_range(0, 7) == 0)
			for (c = 0; c < 4; c++)
				px[CHAN_W*c +: CHAN_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return px;
	endfunction

	task automatic feed_pixels(input int n, input int hold_at);
		int k;
		for (k = 0; k < n; k++) begin
			if (k == hold_at) hold_asks++;
			send_pixel(random_pixel());
		end
	endtask

	function automatic int pick_dim();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return 0;
		if (sel == 1) return $urandom_range(13, 32);
		return $urandom_range(1, 12);
	endfunction

	// result side: short stalls, occasional long hold-off on request
	initial begin
		int holds_done;
		holds_done = 0;
		res_ready <= 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			if (hold_asks != holds_done) begin
				holds_done = hold_asks;
				res_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				res_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// watchdog: cycles without any transfer
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((pix_valid && pix_ready) || (res_valid && res_ready)) quiet = 0;
			else quiet++;
		end
		$display("tb_mip_chain_box_downsample NOT OK");
		$finish;
	end

	initial begin
		int i, w, h, lc, n, area, fed;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= '0;
		pix_valid <= 1'b0;
		{alpha_in, blue_in, green_in, red_in} <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 4x4 image cascades to level 2; sender stops halfway until all results are back
		set_geometry(4, 4, 15);
		for (i = 0; i < 16; i++) begin
			if (i == 8) drain_results();
			send_pixel({8'(i * 17), 8'(255 - i * 17), {8{i[0]}}, {8{~i[1]}}});
		end
		drain_results();

		// zero registers act as one: every pixel is a whole image
		set_geometry(0, 0, 0);
		for (i = 0; i < 3; i++) send_pixel(random_pixel());
		drain_results();

		// odd edges dropped
		set_geometry(3, 3, 13);
		for (i = 0; i < 9; i++) send_pixel(random_pixel());
		drain_results();

		// saturated geometry; long hold-off backs the block up
		set_geometry(4095, 4095, 15);
		feed_pixels(BACKUP_ITEMS, BACKUP_HOLD);
		drain_results();

		fed = 0;
		while (fed < RANDOM_ITEMS) begin
			w = pick_dim();
			h = pick_dim();
			lc = $urandom_range(0, 15);
			area = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
			if ($urandom_range(0, 3) == 0) n = $urandom_range(1, area);
			else n = area * $urandom_range(1, 2);
			if (n > MAX_BURST) n = MAX_BURST;
			set_geometry(w, h, lc);
			feed_pixels(n, -1);
			drain_results();
			fed += n;
		end

		calm = 1'b1;
		set_geometry(16, 16, 5);
		feed_pixels(256, -1);
		drain_results();

		if (fails == 0)
			$display("tb_mip_chain_box_downsample OK");
		else
			$display("tb_mip_chain_box_downsample NOT OK");
		$finish;
	end

endmodule
